// ===== rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros used by the page table walker
// Implication forms of a concurrent assertion with clock and reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/ptw_pkg.sv =====
// ---------------------------------------------------------------------------
// Page table walker package
// Field widths, codes, entry bit positions and the shared request type.
// ---------------------------------------------------------------------------
package ptw_pkg;

  localparam int unsigned AddrW   = 57;
  localparam int unsigned EntryW  = 64;
  localparam int unsigned LevelW  = 3;
  localparam int unsigned IdxW    = 9;
  localparam int unsigned PageOffW = 12;

  localparam int unsigned PresentBit  = 0;
  localparam int unsigned DirtyBit    = 5;
  localparam int unsigned AccessedBit = 6;
  localparam int unsigned SizeBit     = 7;

  typedef logic [AddrW-1:0]  addr_t;
  typedef logic [LevelW-1:0] level_t;

  // input operation codes
  localparam logic OP_TRANSLATE = 1'b0;
  localparam logic OP_RESPONSE  = 1'b1;

  // result kinds
  localparam logic KIND_READ   = 1'b0;
  localparam logic KIND_FINISH = 1'b1;

  // status codes
  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_NOT_PRESENT = 2'd1;
  localparam logic [1:0] ST_PROTO_ERR   = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_LEVELS    = 2'd0;
  localparam logic [1:0] REG_HUGE_1G   = 2'd1;
  localparam logic [1:0] REG_ROOT_BASE = 2'd2;

  localparam level_t LEVEL_MIN = 3'd4;
  localparam level_t LEVEL_MAX = 3'd5;
  localparam level_t LEVEL_ONE = 3'd1;

  // work the address unit does for one step
  typedef enum logic {
    MODE_ENTRY = 1'b0,
    MODE_LEAF  = 1'b1
  } unit_mode_e;

  typedef struct packed {
    unit_mode_e mode;
    level_t     level;
    addr_t      base;
    addr_t      va;
  } unit_req_t;

  // physical address mask: bits 12 .. 9*levels+11
  function automatic addr_t phys_mask(input level_t lvl);
    addr_t m;
    m = '0;
    for (int i = 0; i < AddrW; i++) begin
      if (i >= PageOffW && i < (9 * int'(lvl) + 12)) begin
        m[i] = 1'b1;
      end
    end
    return m;
  endfunction

endpackage

// ===== rtl/ptw_addr_unit.sv =====
// ---------------------------------------------------------------------------
// Page table walker address unit
// Shared unit forming either an entry address or a leaf physical address.
// ---------------------------------------------------------------------------
module ptw_addr_unit (
  input  ptw_pkg::unit_req_t req_i,
  output ptw_pkg::addr_t     addr_o
);

  logic [ptw_pkg::IdxW-1:0] idx;
  logic [5:0]               shift;
  ptw_pkg::addr_t           off_mask;

  always_comb begin
    case (req_i.level)
      3'd1:    shift = 6'd12;
      3'd2:    shift = 6'd21;
      3'd3:    shift = 6'd30;
      3'd4:    shift = 6'd39;
      3'd5:    shift = 6'd48;
      default: shift = 6'd12;
    endcase
  end

  always_comb begin
    case (req_i.level)
      3'd1:    idx = req_i.va[20:12];
      3'd2:    idx = req_i.va[29:21];
      3'd3:    idx = req_i.va[38:30];
      3'd4:    idx = req_i.va[47:39];
      3'd5:    idx = req_i.va[56:48];
      default: idx = '0;
    endcase
  end

  always_comb begin
    for (int i = 0; i < ptw_pkg::AddrW; i++) begin
      off_mask[i] = (i < int'(shift));
    end
  end

  always_comb begin
    case (req_i.mode)
      ptw_pkg::MODE_ENTRY: addr_o = {req_i.base[ptw_pkg::AddrW-1:ptw_pkg::PageOffW], idx, 3'b000};
      ptw_pkg::MODE_LEAF:  addr_o = (req_i.base & ~off_mask) | (req_i.va & off_mask);
      default:             addr_o = '0;
    endcase
  end

endmodule

// ===== rtl/page_table_walker.sv =====
// ---------------------------------------------------------------------------
// Page table walker
// Sequenced four- or five-level walk around a shared address unit.
// ---------------------------------------------------------------------------
// Usage:
//   Slave stream carries translate requests (tuser 0, virtual address in
//   tdata) and memory responses (tuser 1, 64-bit entry in tdata). Master
//   stream returns one result per input: tuser 0 is a read of the entry at
//   the given address, tuser 1 a finished walk with status, page size and
//   the dirty and accessed bits. The caller answers each read with one
//   response transaction carrying the entry.
//   Each transaction is captured at the accept edge, then steps through
//   the address unit, whose result is loaded into the output register. The
//   slave side is not ready during the unit step, so a new transaction is
//   accepted only once the last one has left it; the result shows on the
//   master side in the cycle after the unit step. The single address unit
//   and the sequencer allow one transaction in the unit step at a time.
//   If the receiver stalls, the result is held in the output register and
//   one more transaction may still be accepted; its unit step then waits
//   until the held result is taken.
//   Reset clears the walk (idle), the output register valid and loads the
//   register defaults: four levels, no 1GiB pages, root base zero.
//   Configuration writes go through their own channel, always ready.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module page_table_walker (
  input  logic         clk_i,
  input  logic         rst_ni,
  // slave stream
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [127:0] s_axis_tdata_i,   // virt_address[56:0], read_data[120:57], zero pad
  input  logic         s_axis_tuser_i,   // operation
  // master stream
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  output logic [63:0]  m_axis_tdata_o,   // address[56:0], status[58:57], page_size[60:59],
                                         // dirty[61], accessed[62], zero pad
  output logic         m_axis_tuser_o,   // kind
  // configuration write channel
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [1:0]   cfg_index_i,
  input  logic [56:0]  cfg_data_i
);

  typedef enum logic {
    S_IDLE = 1'b0,
    S_CALC = 1'b1
  } state_e;

  // configuration
  ptw_pkg::level_t levels_q;
  logic            huge_1g_q;
  ptw_pkg::addr_t  root_base_q;

  // sequencer and walk state
  state_e          state_q;
  logic            walk_busy_q, walk_busy_d;
  ptw_pkg::level_t walk_level_q, walk_level_d;
  ptw_pkg::addr_t  held_va_q, held_va_d;

  // captured transaction
  logic                        in_op_q;
  ptw_pkg::addr_t              in_va_q;
  logic [ptw_pkg::EntryW-1:0]  in_data_q;

  // output register
  logic        m_valid_q;
  logic        m_kind_q, m_kind_d;
  logic [63:0] m_data_q, m_data_d;

  // shared unit
  ptw_pkg::unit_req_t unit_req;
  ptw_pkg::addr_t     unit_addr;

  ptw_pkg::level_t eff_levels;
  ptw_pkg::addr_t  ent_base;
  logic            present, is_leaf;
  ptw_pkg::level_t leaf_max;
  logic            out_free, s_accept, step_done;

  logic [1:0] st;
  logic [1:0] psize;
  logic       dirty, accessed;
  logic       use_unit;
  ptw_pkg::addr_t out_addr;

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign s_accept        = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !m_valid_q || m_axis_tready_i;
  assign step_done       = (state_q == S_CALC) && out_free;
  assign cfg_ready_o     = 1'b1;

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tuser_o  = m_kind_q;
  assign m_axis_tdata_o  = m_data_q;

  // clamp the level count to four or five
  always_comb begin
    if (levels_q < ptw_pkg::LEVEL_MIN) begin
      eff_levels = ptw_pkg::LEVEL_MIN;
    end else if (levels_q > ptw_pkg::LEVEL_MAX) begin
      eff_levels = ptw_pkg::LEVEL_MAX;
    end else begin
      eff_levels = levels_q;
    end
  end

  assign ent_base = in_data_q[ptw_pkg::AddrW-1:0] & ptw_pkg::phys_mask(eff_levels);
  assign present  = in_data_q[ptw_pkg::PresentBit];
  assign leaf_max = huge_1g_q ? 3'd3 : 3'd2;
  assign is_leaf  = (walk_level_q == ptw_pkg::LEVEL_ONE) ||
                    ((walk_level_q <= leaf_max) && in_data_q[ptw_pkg::SizeBit]);

  // steer the shared unit and decide the walk step
  always_comb begin
    unit_req.mode  = ptw_pkg::MODE_ENTRY;
    unit_req.level = eff_levels;
    unit_req.base  = root_base_q;
    unit_req.va    = in_va_q;
    walk_busy_d    = walk_busy_q;
    walk_level_d   = walk_level_q;
    held_va_d      = held_va_q;
    m_kind_d       = ptw_pkg::KIND_FINISH;
    st             = ptw_pkg::ST_PROTO_ERR;
    psize          = 2'd0;
    dirty          = 1'b0;
    accessed       = 1'b0;
    use_unit       = 1'b0;
    if (in_op_q == ptw_pkg::OP_TRANSLATE) begin
      if (!walk_busy_q) begin
        // start a walk at the top table
        held_va_d    = in_va_q;
        walk_level_d = eff_levels;
        walk_busy_d  = 1'b1;
        m_kind_d     = ptw_pkg::KIND_READ;
        st           = ptw_pkg::ST_OK;
        use_unit     = 1'b1;
      end
    end else begin
      unit_req.va   = held_va_q;
      unit_req.base = ent_base;
      if (!walk_busy_q) begin
        walk_level_d = '0;
      end else if (!present) begin
        walk_busy_d  = 1'b0;
        walk_level_d = '0;
        st           = ptw_pkg::ST_NOT_PRESENT;
      end else if (is_leaf) begin
        unit_req.mode  = ptw_pkg::MODE_LEAF;
        unit_req.level = walk_level_q;
        walk_busy_d    = 1'b0;
        walk_level_d   = '0;
        st             = ptw_pkg::ST_OK;
        psize          = 2'(walk_level_q - ptw_pkg::LEVEL_ONE);
        dirty          = in_data_q[ptw_pkg::DirtyBit];
        accessed       = in_data_q[ptw_pkg::AccessedBit];
        use_unit       = 1'b1;
      end else begin
        // descend into the next table
        unit_req.level = walk_level_q - ptw_pkg::LEVEL_ONE;
        walk_level_d   = walk_level_q - ptw_pkg::LEVEL_ONE;
        m_kind_d       = ptw_pkg::KIND_READ;
        st             = ptw_pkg::ST_OK;
        use_unit       = 1'b1;
      end
    end
  end

  ptw_addr_unit u_addr (
    .req_i  (unit_req),
    .addr_o (unit_addr)
  );

  // drop the unit address on error and not-present results
  assign out_addr = use_unit ? unit_addr : '0;
  assign m_data_d = {1'b0, accessed, dirty, psize, st, out_addr};

  // sequencer, walk state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      walk_busy_q  <= 1'b0;
      walk_level_q <= '0;
      held_va_q    <= '0;
      m_valid_q    <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (s_accept) begin
            state_q <= S_CALC;
          end
        end
        S_CALC: begin
          if (step_done) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
      if (step_done) begin
        walk_busy_q  <= walk_busy_d;
        walk_level_q <= walk_level_d;
        held_va_q    <= held_va_d;
        m_valid_q    <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q    <= 1'b0;
      end
    end
  end

  // payload: captured transaction and result data
  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      in_op_q   <= s_axis_tuser_i;
      in_va_q   <= s_axis_tdata_i[56:0];
      in_data_q <= s_axis_tdata_i[120:57];
    end
    if (step_done) begin
      m_kind_q <= m_kind_d;
      m_data_q <= m_data_d;
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      levels_q    <= ptw_pkg::LEVEL_MIN;
      huge_1g_q   <= 1'b0;
      root_base_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        ptw_pkg::REG_LEVELS:    levels_q    <= cfg_data_i[2:0];
        ptw_pkg::REG_HUGE_1G:   huge_1g_q   <= cfg_data_i[0];
        ptw_pkg::REG_ROOT_BASE: root_base_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // a live walk always sits on a real level
  `ASSERT_IMP(a_level_range, clk_i, rst_ni, walk_busy_q,
              walk_level_q >= ptw_pkg::LEVEL_ONE && walk_level_q <= ptw_pkg::LEVEL_MAX)
  // an accepted transaction always moves into the unit step
  `ASSERT_NXT(a_accept_calc, clk_i, rst_ni, s_accept, state_q == S_CALC)
  // a finished walk leaves the walker idle
  `ASSERT_NXT(a_finish_idle, clk_i, rst_ni,
              step_done && in_op_q == ptw_pkg::OP_RESPONSE,
              !walk_busy_q || m_kind_q == ptw_pkg::KIND_READ)
  // a read request always carries an ok status
  `ASSERT_IMP(a_read_ok, clk_i, rst_ni,
              m_valid_q && m_kind_q == ptw_pkg::KIND_READ, m_data_q[58:57] == ptw_pkg::ST_OK)

endmodule
